// ===== design/htbd_pkg.sv =====
// Shared types and constants for the bit-serial Huffman tree decoder.
// Used by the channel interfaces, the node table RAM and the decoder core.
`default_nettype none

package htbd_pkg;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 9;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int NODE_DEPTH_DEF   = 512;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_BIT  = 2'd1,
    ACT_END  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_SYMBOL    = 2'd0,
    ST_MISSING   = 2'd1,
    ST_PHANTOM   = 2'd2,
    ST_EARLY_END = 2'd3
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
    logic                    has_left;
    logic                    has_right;
    logic signed [SYM_W-1:0] symbol;
  } node_t;

endpackage

`default_nettype wire

// ===== design/htbd_if.sv =====
// Valid/ready channel interfaces for the decoder's request and result streams.
// Depends on htbd_pkg for field widths.
`default_nettype none

interface htbd_in_if import htbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic                    code_bit;
  logic [IDX_W-1:0]        node_index;
  logic [IDX_W-1:0]        left_index;
  logic [IDX_W-1:0]        right_index;
  logic                    has_left;
  logic                    has_right;
  logic signed [SYM_W-1:0] leaf_symbol;

  modport source (
    output valid, action, code_bit, node_index, left_index, right_index,
           has_left, has_right, leaf_symbol,
    input  ready
  );

  modport sink (
    input  valid, action, code_bit, node_index, left_index, right_index,
           has_left, has_right, leaf_symbol,
    output ready
  );
endinterface

interface htbd_out_if import htbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol_out;
  logic [1:0]        status;
  logic              finished;

  modport source (
    output valid, symbol_out, status, finished,
    input  ready
  );

  modport sink (
    input  valid, symbol_out, status, finished,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/huffman_tree_bit_decoder_core.sv =====
// Huffman tree decoder core: walks the node table one code bit per request.
// Depends on htbd_pkg, htbd_in_if, htbd_out_if and htbd_node_ram.
//
//   Channel   Dir  Handshake      Carries
//   din       in   valid/ready    action, code bit, node load fields
//   dout      out  valid/ready    symbol_out, status, finished
//   cfg       in   cfg_wr_en      symbols_to_decode
//
// One request per cycle is accepted. A code bit reads its child entry from the
// node table RAM when accepted; the tree step is resolved from that registered
// read data, and its result is registered into dout. The entry of the current
// node is held in a register and forwarded from the resolving step to the next
// read. Reset clears the walk position, the symbol count and the halt flag; the
// node table is not cleared. Requests stall only while a result waits in dout.
`default_nettype none

module huffman_tree_bit_decoder_core import htbd_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int NODE_DEPTH   = NODE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  htbd_in_if.sink          din,
  htbd_out_if.source       dout
);

  localparam int AW = $clog2(NODE_DEPTH);
  localparam logic [IDX_W:0]   DepthLim = (IDX_W+1)'(NODE_DEPTH);
  localparam logic [SYM_W-1:0] SymLim   = SYM_W'(SYMBOL_COUNT);

  logic [CNT_W-1:0]  symbols_to_decode;
  logic [CNT_W-1:0]  decoded_count;
  logic              halted;
  node_t             cur;
  logic [AW-1:0]     cur_idx;
  node_t             root;
  logic              s1_valid;
  logic              s1_is_end;
  logic              s1_bit;
  node_t             s1_cur;
  logic              out_valid;
  logic [BYTE_W-1:0] out_symbol;
  status_t           out_status;
  logic              out_finished;

  node_t             cur_next;
  logic [AW-1:0]     cur_idx_next;
  node_t             root_next;

  node_t             rdata;
  node_t             load_node;
  logic              in_acc;
  logic              load_ok;
  logic              step_acc;
  logic              bit_acc;
  logic [IDX_W-1:0]  rd_idx;

  logic              gated;
  logic              visit;
  node_t             vnode;
  logic              present;
  logic [IDX_W-1:0]  nxt;
  logic [CNT_W-1:0]  count_inc;
  logic              s1_emit;
  status_t           s1_status;
  logic [BYTE_W-1:0] s1_sym;
  logic              s1_fin;
  logic              s1_halt;
  logic              s1_inc;
  node_t             s1_cur_new;
  logic [AW-1:0]     s1_idx_new;
  logic              s1_adv;
  logic              commit;

  assign in_acc   = din.valid && din.ready;
  assign load_ok  = in_acc && (din.action == ACT_LOAD) && ({1'b0, din.node_index} < DepthLim);
  assign bit_acc  = in_acc && (din.action == ACT_BIT);
  assign step_acc = bit_acc || (in_acc && (din.action == ACT_END));

  assign load_node = '{left:      din.left_index,
                       right:     din.right_index,
                       has_left:  din.has_left,
                       has_right: din.has_right,
                       symbol:    din.leaf_symbol};

  assign rd_idx = din.code_bit ? s1_cur_new.right : s1_cur_new.left;

  htbd_node_ram #(
    .NODE_DEPTH (NODE_DEPTH),
    .AW         (AW)
  ) u_node_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (din.node_index[AW-1:0]),
    .wdata (load_node),
    .re    (bit_acc),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  assign gated     = halted || (decoded_count >= symbols_to_decode);
  assign count_inc = decoded_count + CNT_W'(1);
  assign present   = s1_bit ? s1_cur.has_right : s1_cur.has_left;
  assign nxt       = s1_bit ? s1_cur.right : s1_cur.left;

  always_comb begin
    s1_emit    = 1'b0;
    s1_status  = ST_SYMBOL;
    s1_sym     = '0;
    s1_fin     = 1'b0;
    s1_halt    = 1'b0;
    s1_inc     = 1'b0;
    s1_cur_new = cur;
    s1_idx_new = cur_idx;
    visit      = 1'b0;
    vnode      = s1_cur;
    if (s1_valid && !gated) begin
      if (s1_is_end) begin
        s1_emit   = 1'b1;
        s1_status = ST_EARLY_END;
        s1_fin    = 1'b1;
        s1_halt   = 1'b1;
      end else if (!s1_cur.has_left && !s1_cur.has_right) begin
        visit = 1'b1;
      end else if (!present || ({1'b0, nxt} >= DepthLim)) begin
        s1_emit   = 1'b1;
        s1_status = ST_MISSING;
        s1_fin    = 1'b1;
        s1_halt   = 1'b1;
      end else begin
        s1_cur_new = rdata;
        s1_idx_new = nxt[AW-1:0];
        vnode      = rdata;
        visit      = !rdata.has_left && !rdata.has_right;
      end
      if (visit) begin
        s1_emit = 1'b1;
        if (vnode.symbol[SYM_W-1] || ({1'b0, vnode.symbol[SYM_W-2:0]} >= SymLim)) begin
          s1_status = ST_PHANTOM;
          s1_fin    = 1'b1;
          s1_halt   = 1'b1;
        end else begin
          s1_sym     = vnode.symbol[BYTE_W-1:0];
          s1_inc     = 1'b1;
          s1_fin     = count_inc >= symbols_to_decode;
          s1_cur_new = root;
          s1_idx_new = '0;
        end
      end
    end
  end

  assign s1_adv    = !s1_emit || !out_valid || dout.ready;
  assign commit    = s1_valid && s1_adv;
  assign din.ready = !s1_valid || s1_adv;

  always_comb begin
    cur_next     = commit ? s1_cur_new : cur;
    cur_idx_next = commit ? s1_idx_new : cur_idx;
    root_next    = root;
    if (load_ok && (din.node_index[AW-1:0] == cur_idx_next)) begin
      cur_next = load_node;
    end
    if (load_ok && (din.node_index[AW-1:0] == '0)) begin
      root_next = load_node;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    root <= root_next;
    if (step_acc) begin
      s1_is_end <= (din.action == ACT_END);
      s1_bit    <= din.code_bit;
      s1_cur    <= s1_cur_new;
    end
    if (commit && s1_emit) begin
      out_symbol   <= s1_sym;
      out_status   <= s1_status;
      out_finished <= s1_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_to_decode <= '0;
      decoded_count     <= '0;
      halted            <= 1'b0;
      cur_idx           <= '0;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        symbols_to_decode <= cfg_wr_data;
      end
      if (commit && s1_inc) begin
        decoded_count <= count_inc;
      end
      if (commit && s1_halt) begin
        halted <= 1'b1;
      end
      cur_idx <= cur_idx_next;
      if (din.ready) begin
        s1_valid <= step_acc;
      end
      if (commit && s1_emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dout.valid      = out_valid;
  assign dout.symbol_out = out_symbol;
  assign dout.status     = out_status;
  assign dout.finished   = out_finished;

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("Decoder left the halted state without a reset.");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (decoded_count >= $past(decoded_count)))
    else $error("Decoded symbol count went backward.");

  a_error_finishes: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.status == ST_SYMBOL || dout.finished))
    else $error("An error result was not marked finished.");

  a_no_result_halted: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && halted) |-> !s1_emit)
    else $error("A result was produced after decoding halted.");
`endif

endmodule

`default_nettype wire

// ===== design/htbd_node_ram.sv =====
// Node table storage: one write port, one registered read port.
// Depends on htbd_pkg for the node entry type.
`default_nettype none

module htbd_node_ram import htbd_pkg::*; #(
  parameter int NODE_DEPTH = NODE_DEPTH_DEF,
  parameter int AW         = $clog2(NODE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  node_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output node_t         rdata
);

  node_t mem [NODE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for huffman_tree_bit_decoder_core: loads code trees, streams
// code bits and compares every result with a tree walk kept alongside the block.
// Depends on htbd_pkg, the htbd_in_if/htbd_out_if interfaces and the decoder core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htbd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT = 13;

  typedef struct {
    logic [1:0]       action;
    logic             code_bit;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic             has_left;
    logic             has_right;
    logic [SYM_W-1:0] leaf_symbol;
  } request_t;

  typedef struct {
    logic [BYTE_W-1:0] symbol;
    logic [1:0]        status;
    logic              finished;
  } decoded_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  htbd_in_if din_if ();
  htbd_out_if dout_if ();

  huffman_tree_bit_decoder_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .din         (din_if),
    .dout        (dout_if)
  );

  request_t request_queue[$];
  decoded_t expected_symbols[$];
  int unsigned cycle_cnt = 0;
  int err_cnt = 0;
  logic req_taken = 1'b0;

  node_t tree_mem [NODE_DEPTH_DEF];
  logic [IDX_W-1:0] walk_node = '0;
  logic [CNT_W-1:0] decode_count = '0;
  logic [CNT_W-1:0] decode_limit = '0;
  logic decode_halted = 1'b0;

  node_t plan_mem [NODE_DEPTH_DEF];
  bit plan_written [NODE_DEPTH_DEF];
  bit plan_in_tree [NODE_DEPTH_DEF];
  int plan_written_cnt = 0;
  int gen_cnt = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit is_leaf(node_t n);
    return !n.has_left && !n.has_right;
  endfunction

  function automatic bit calm_window();
    return (cycle_cnt % 4000) >= 1000 && (cycle_cnt % 4000) < 1800;
  endfunction

  function automatic void emit_leaf(node_t n);
    if (n.symbol[SYM_W-1]) begin
      decode_halted = 1'b1;
      expected_symbols.push_back(decoded_t'{'0, ST_PHANTOM, 1'b1});
    end else begin
      decode_count++;
      walk_node = '0;
      expected_symbols.push_back(decoded_t'{n.symbol[BYTE_W-1:0], ST_SYMBOL,
                                            decode_count >= decode_limit});
    end
  endfunction

  function automatic void walk_tree(request_t r);
    node_t cur;
    logic present;
    logic [IDX_W-1:0] next_node;
    if (r.action == ACT_LOAD) begin
      tree_mem[r.node_index] = '{r.left_index, r.right_index, r.has_left, r.has_right,
                                 r.leaf_symbol};
      return;
    end
    if (r.action == ACT_UNUSED || decode_halted || decode_count >= decode_limit) return;
    if (r.action == ACT_END) begin
      decode_halted = 1'b1;
      expected_symbols.push_back(decoded_t'{'0, ST_EARLY_END, 1'b1});
      return;
    end
    cur = tree_mem[walk_node];
    if (is_leaf(cur)) begin
      emit_leaf(cur);
      return;
    end
    present = r.code_bit ? cur.has_right : cur.has_left;
    next_node = r.code_bit ? cur.right : cur.left;
    if (!present) begin
      decode_halted = 1'b1;
      expected_symbols.push_back(decoded_t'{'0, ST_MISSING, 1'b1});
      return;
    end
    walk_node = next_node;
    cur = tree_mem[next_node];
    if (is_leaf(cur)) emit_leaf(cur);
  endfunction

  function automatic request_t noise_request(logic [1:0] act);
    request_t r;
    r.action = act;
    r.code_bit = 1'($urandom);
    r.node_index = IDX_W'($urandom);
    r.left_index = IDX_W'($urandom);
    r.right_index = IDX_W'($urandom);
    r.has_left = 1'($urandom);
    r.has_right = 1'($urandom);
    r.leaf_symbol = SYM_W'($urandom);
    return r;
  endfunction

  function automatic void queue_request(request_t r);
    if (r.action == ACT_LOAD) begin
      plan_mem[r.node_index] = '{r.left_index, r.right_index, r.has_left, r.has_right,
                                 r.leaf_symbol};
      if (!plan_written[r.node_index]) begin
        plan_written[r.node_index] = 1'b1;
        plan_written_cnt++;
      end
    end
    if (r.action != ACT_UNUSED) gen_cnt++;
    request_queue.push_back(r);
  endfunction

  function automatic void queue_load(int idx, int l, int rgt, bit hl, bit hr,
                                     logic [SYM_W-1:0] sym);
    request_t r;
    r = noise_request(ACT_LOAD);
    r.node_index = IDX_W'(idx);
    r.left_index = IDX_W'(l);
    r.right_index = IDX_W'(rgt);
    r.has_left = hl;
    r.has_right = hr;
    r.leaf_symbol = sym;
    queue_request(r);
  endfunction

  function automatic void queue_bit(bit b);
    request_t r;
    r = noise_request(ACT_BIT);
    r.code_bit = b;
    queue_request(r);
  endfunction

  function automatic int any_written(int self);
    int idx;
    if (plan_written_cnt == 0) return self;
    do idx = $urandom_range(NODE_DEPTH_DEF - 1); while (!plan_written[idx]);
    return idx;
  endfunction

  function automatic int any_leaf(int avoid);
    int idx;
    do idx = $urandom_range(NODE_DEPTH_DEF - 1);
    while (idx == avoid || !plan_written[idx] || !is_leaf(plan_mem[idx]) ||
           plan_mem[idx].symbol[SYM_W-1]);
    return idx;
  endfunction

  function automatic int fresh_node();
    int idx;
    do idx = $urandom_range(NODE_DEPTH_DEF - 1, 1); while (plan_in_tree[idx]);
    plan_in_tree[idx] = 1'b1;
    return idx;
  endfunction

  function automatic void queue_leaf(int idx, logic [SYM_W-1:0] sym);
    queue_load(idx, any_written(idx), any_written(idx), 1'b0, 1'b0, sym);
  endfunction

  // Leaves go in first and every parent after its children, so the table
  // never holds a reachable entry that has not been written.
  function automatic void build_tree(int leaves);
    int roots[$];
    int a, b, pos, parent;
    plan_in_tree = '{default: 1'b0};
    plan_in_tree[0] = 1'b1;
    if (leaves == 1) begin
      queue_leaf(0, SYM_W'($urandom_range(255)));
      return;
    end
    repeat (leaves) begin
      a = fresh_node();
      queue_leaf(a, SYM_W'($urandom_range(255)));
      roots.push_back(a);
    end
    while (roots.size() > 1) begin
      pos = $urandom_range(roots.size() - 1);
      a = roots[pos];
      roots.delete(pos);
      pos = $urandom_range(roots.size() - 1);
      b = roots[pos];
      roots.delete(pos);
      parent = (roots.size() == 0) ? 0 : fresh_node();
      queue_load(parent, a, b, 1'b1, 1'b1, SYM_W'($urandom));
      roots.push_back(parent);
    end
  endfunction

  task automatic wait_quiet();
    do @(posedge clk);
    while (request_queue.size() != 0 || din_if.valid || expected_symbols.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    decode_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_requests
    request_t r;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || req_taken) begin
      if (request_queue.size() != 0 && (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
        r = request_queue.pop_front();
        din_if.action <= r.action;
        din_if.code_bit <= r.code_bit;
        din_if.node_index <= r.node_index;
        din_if.left_index <= r.left_index;
        din_if.right_index <= r.right_index;
        din_if.has_left <= r.has_left;
        din_if.has_right <= r.has_right;
        din_if.leaf_symbol <= r.leaf_symbol;
        din_if.valid <= 1'b1;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    dout_if.ready <= !rst && (calm_window() || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    request_t seen;
    decoded_t want;
    cycle_cnt <= cycle_cnt + 1;
    req_taken <= din_if.valid && din_if.ready;
    if (!rst) begin
      if (din_if.valid && din_if.ready) begin
        seen = '{din_if.action, din_if.code_bit, din_if.node_index, din_if.left_index,
                 din_if.right_index, din_if.has_left, din_if.has_right, din_if.leaf_symbol};
        walk_tree(seen);
      end
      if (dout_if.valid && dout_if.ready) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected result: symbol_out %0d, status %0d, finished %0d",
                 dout_if.symbol_out, dout_if.status, dout_if.finished);
          err_cnt++;
        end else begin
          want = expected_symbols.pop_front();
          if (dout_if.symbol_out !== want.symbol) begin
            $error("symbol_out: expected %0d, got %0d", want.symbol, dout_if.symbol_out);
            err_cnt++;
          end
          if (dout_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, dout_if.status);
            err_cnt++;
          end
          if (dout_if.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, dout_if.finished);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int nbits, lf, ph, idx;
    bit side;
    bit new_tree;
    din_if.valid = 1'b0;
    din_if.action = ACT_LOAD;
    din_if.code_bit = 1'b0;
    din_if.node_index = '0;
    din_if.left_index = '0;
    din_if.right_index = '0;
    din_if.has_left = 1'b0;
    din_if.has_right = 1'b0;
    din_if.leaf_symbol = '0;
    dout_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_limit('0);
    queue_leaf(511, 9'd255);
    queue_leaf(1, 9'd0);
    queue_leaf(510, 9'd128);
    queue_load(256, 1, 510, 1'b1, 1'b1, 9'h1FF);
    queue_load(0, 511, 256, 1'b1, 1'b1, 9'h100);
    queue_bit(1'b0);
    queue_request(noise_request(ACT_END));
    queue_request(noise_request(ACT_UNUSED));
    wait_quiet();

    write_limit(6);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_leaf(1, 9'd77);
    queue_bit(1'b0);
    queue_request(noise_request(ACT_UNUSED));
    queue_bit(1'b1);
    queue_bit(1'b1);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_bit(1'b0);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_request(noise_request(ACT_END));
    wait_quiet();

    write_limit(8);
    queue_leaf(0, 9'd200);
    queue_bit(1'b1);
    queue_bit(1'b0);

    gen_cnt = 0;
    new_tree = 1'b1;
    while (gen_cnt < RANDOM_REQUESTS) begin
      wait_quiet();
      if (decode_count >= decode_limit) begin
        repeat ($urandom_range(2))
          queue_request(noise_request($urandom_range(1) ? ACT_END : ACT_BIT));
        wait_quiet();
      end
      case ($urandom_range(11))
        0: write_limit(decode_count);
        1: write_limit('1);
        default: write_limit(decode_count + CNT_W'($urandom_range(30, 1)));
      endcase
      if (new_tree || $urandom_range(2) == 0)
        build_tree(($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1));
      new_tree = 1'b0;
      nbits = $urandom_range(120, 10);
      repeat (nbits) begin
        case ($urandom_range(99)) inside
          [0:5]: begin
            do idx = $urandom_range(NODE_DEPTH_DEF - 1, 1); while (plan_in_tree[idx]);
            if ($urandom_range(1))
              queue_leaf(idx, SYM_W'($urandom_range(255)));
            else
              queue_load(idx, any_leaf(idx), any_leaf(idx), 1'b1, 1'b1, SYM_W'($urandom));
          end
          [6:8]: queue_request(noise_request(ACT_UNUSED));
          default: queue_bit(1'($urandom));
        endcase
      end
    end

    // Any error halts the decoder until reset, so exactly one kind is raised
    // at the end of the run.
    wait_quiet();
    write_limit('1);
    while (walk_node != '0) begin
      queue_bit(1'($urandom));
      wait_quiet();
    end
    side = 1'($urandom_range(1));
    lf = any_leaf(0);
    case ($urandom_range(3))
      0: begin
        queue_load(0, lf, lf, side == 0, side == 1, SYM_W'($urandom));
        queue_bit(side);
        queue_bit(side);
        queue_bit(!side);
      end
      1: begin
        do ph = $urandom_range(NODE_DEPTH_DEF - 1, 1); while (ph == lf);
        queue_leaf(ph, SYM_W'(512 - $urandom_range(256, 1)));
        queue_load(0, side ? lf : ph, side ? ph : lf, 1'b1, 1'b1, SYM_W'($urandom));
        queue_bit(!side);
        queue_bit(!side);
        queue_bit(side);
      end
      2: begin
        queue_leaf(0, SYM_W'(512 - $urandom_range(256, 1)));
        queue_bit(side);
      end
      default: begin
        repeat ($urandom_range(4)) queue_bit(1'($urandom));
        queue_request(noise_request(ACT_END));
      end
    endcase
    repeat (20) begin
      case ($urandom_range(3))
        0: queue_leaf($urandom_range(NODE_DEPTH_DEF - 1, 1), SYM_W'($urandom));
        1: queue_bit(1'($urandom));
        2: queue_request(noise_request(ACT_END));
        default: queue_request(noise_request(ACT_UNUSED));
      endcase
    end
    wait_quiet();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/htbd_pkg.sv
design/htbd_if.sv
design/htbd_node_ram.sv
design/huffman_tree_bit_decoder_core.sv
tb/sv/tb.sv
